// ----- rtl/stle_pkg.sv -----
`timescale 1ns / 1ps
// Package: widths, codes, tables and small trit helpers for the tryte length encoder.
package stle_pkg;

	localparam int VALUE_W        = 64;
	localparam int CAP_W          = 6;
	localparam int TRIT_W         = 2;
	localparam int POS_W          = 6;
	localparam int IN_W           = 72;
	localparam int OUT_W          = 8;

	// Divide-by-three unit: one 16-bit chunk per cycle, most significant first.
	localparam int CHUNK_W        = 16;
	localparam int N_CHUNKS       = VALUE_W / CHUNK_W;
	localparam int CHUNK_IDX_W    = 2;
	localparam int DIV_IN_W       = CHUNK_W + 2;
	localparam int DIV_MULT_W     = 18;
	localparam int DIV_SHIFT      = 19;
	// (2^19 + 1) / 3, exact for every dividend below 2^19.
	localparam logic [DIV_MULT_W-1:0] DIV_MULT = 18'd174763;

	localparam int TRYTE_TRITS    = 3;
	localparam int TRYTE_W        = TRYTE_TRITS * TRIT_W;
	localparam int MAX_TRYTES     = 14;
	localparam int TRYTE_IDX_W    = 4;
	localparam int MAX_FLAG_TRITS = 10;
	localparam int FLAG_IDX_W     = 4;
	localparam int ZERO_LEN       = 4;

	localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'b00;
	localparam logic [TRIT_W-1:0] TRIT_POS  = 2'b01;
	localparam logic [TRIT_W-1:0] TRIT_NEG  = 2'b11;

	typedef logic [TRIT_W-1:0]  trit_t;
	typedef logic [TRYTE_W-1:0] tryte_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_DIV,
		ST_TRYTE,
		ST_LEN,
		ST_EMIT,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] quot;
		logic [1:0]         rem;
	} div_res_t;

	// Trits needed for the flag word of k trytes, that is for 2^k - 1.
	function automatic logic [FLAG_IDX_W-1:0] flag_trits(input logic [TRYTE_IDX_W-1:0] k);
		logic [FLAG_IDX_W-1:0] n;
		unique case (k)
			4'd1:    n = 4'd1;
			4'd2:    n = 4'd2;
			4'd3:    n = 4'd3;
			4'd4:    n = 4'd4;
			4'd5:    n = 4'd4;
			4'd6:    n = 4'd5;
			4'd7:    n = 4'd6;
			4'd8:    n = 4'd6;
			4'd9:    n = 4'd7;
			4'd10:   n = 4'd7;
			4'd11:   n = 4'd8;
			4'd12:   n = 4'd9;
			4'd13:   n = 4'd9;
			4'd14:   n = 4'd10;
			default: n = 4'd1;
		endcase
		return n;
	endfunction

	// Fixed encoding of a zero value.
	function automatic trit_t zero_code(input logic [1:0] idx);
		trit_t t;
		unique case (idx)
			2'd0:    t = TRIT_POS;
			2'd3:    t = TRIT_NEG;
			default: t = TRIT_ZERO;
		endcase
		return t;
	endfunction

	// Remainder r of (n + 1) / 3 gives the balanced digit r - 1.
	function automatic trit_t rem_to_trit(input logic [1:0] r);
		trit_t t;
		unique case (r)
			2'd0:    t = TRIT_NEG;
			2'd2:    t = TRIT_POS;
			default: t = TRIT_ZERO;
		endcase
		return t;
	endfunction

	function automatic trit_t trit_neg(input trit_t t);
		return ~t + trit_t'(1);
	endfunction

	function automatic tryte_t tryte_neg(input tryte_t tr);
		return {trit_neg(tr[5:4]), trit_neg(tr[3:2]), trit_neg(tr[1:0])};
	endfunction

	// Value of a tryte, least significant trit in the low bits; range -13..13.
	function automatic logic signed [4:0] tryte_val(input tryte_t tr);
		logic signed [4:0] a0;
		logic signed [4:0] a1;
		logic signed [4:0] a2;
		a0 = {{3{tr[1]}}, tr[1:0]};
		a1 = {{3{tr[3]}}, tr[3:2]};
		a2 = {{3{tr[5]}}, tr[5:4]};
		return a0 + a1 * 5'sd3 + a2 * 5'sd9;
	endfunction

endpackage

// ----- rtl/signed_tryte_length_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the signed tryte length encoder: sequencer, trit buffers and output register.
// Sequence: each data trit takes one increment and four 16-bit passes through the shared
// divide-by-three unit while the remaining magnitude is nonzero, the increment alone once it is
// zero; each tryte adds a tryte step, then come the length check, the flag trits made the same
// way, and the emission of the trits, which waits while the output is stalled.
// One item at a time: the next item is accepted once the last result sits in the output register.
// Reset: arst_n clears the sequencer and the output valid asynchronously; data holds no reset.
module signed_tryte_length_encoder import stle_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [63:0] value, [69:64] capacity, [71:70] zero
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // [1:0] trit, [7:2] position
	output logic             m_tlast,
	output logic [0:0]       m_tuser    // [0] status: capacity too small
);

	// The value is converted to balanced ternary one digit at a time by repeated
	// division of (n + 1) by three. The division runs over four 16-bit chunks in
	// the shared unit, so the working register shifts left by one chunk per cycle
	// and holds the full quotient after the fourth pass.

	state_t state_q, state_d;

	logic [VALUE_W-1:0]     value_in;
	logic [CAP_W-1:0]       cap_in;
	logic [VALUE_W-1:0]     mag_in;

	logic [VALUE_W-1:0]     n_q;
	logic [1:0]             rem_q;
	logic [CHUNK_IDX_W-1:0] chunk_q;
	logic                   neg_q;
	logic                   zero_q;
	logic                   flag_mode_q;
	logic [CAP_W-1:0]       cap_q;

	tryte_t                 acc_q;
	logic [1:0]             tsub_q;
	tryte_t                 tbuf_q [MAX_TRYTES];
	logic [TRYTE_IDX_W-1:0] ntry_q;
	logic [MAX_TRYTES-1:0]  flags_q;
	trit_t                  fbuf_q [MAX_FLAG_TRITS];
	logic [FLAG_IDX_W-1:0]  fcnt_q;
	logic [FLAG_IDX_W-1:0]  clen_q;
	logic [POS_W-1:0]       total_q;

	logic [POS_W-1:0]       pos_q;
	logic [TRYTE_IDX_W-1:0] rd_try_q;
	logic [1:0]             rd_sub_q;
	logic [FLAG_IDX_W-1:0]  rd_flag_q;

	logic                   m_valid_q;
	trit_t                  m_trit_q;
	logic [POS_W-1:0]       m_pos_q;
	logic                   m_last_q;
	logic                   m_status_q;

	div_res_t               div_res;

	logic                   n_zero;
	logic                   digit_done;
	trit_t                  raw_trit;
	trit_t                  data_trit;
	state_t                 digit_next;
	logic signed [4:0]      tval;
	logic                   flip;
	tryte_t                 flipped;
	logic [POS_W-1:0]       total_calc;
	logic                   cap_ok;
	logic                   out_free;
	logic                   out_load;
	tryte_t                 rd_tryte;
	trit_t                  emit_trit;
	logic                   emit_last;
	logic                   in_data;

	assign value_in = s_tdata[VALUE_W-1:0];
	assign cap_in   = s_tdata[VALUE_W +: CAP_W];
	// The most negative value wraps to 2^63, which is its true magnitude.
	assign mag_in   = value_in[VALUE_W-1] ? (~value_in + VALUE_W'(1)) : value_in;

	stle_div3 u_div (
		.rem_in (rem_q),
		.chunk  (n_q[VALUE_W-1 -: CHUNK_W]),
		.res    (div_res)
	);

	// Outputs and datapath controls of the sequencer.
	always_comb begin
		n_zero     = (n_q == '0);
		s_tready   = (state_q == ST_IDLE);
		digit_done = ((state_q == ST_INC) && n_zero) ||
		             ((state_q == ST_DIV) && (chunk_q == '0));
		raw_trit   = (state_q == ST_DIV) ? rem_to_trit(div_res.rem) : TRIT_ZERO;
		data_trit  = neg_q ? trit_neg(raw_trit) : raw_trit;

		// Every tryte but the last must end up negative, the last one positive.
		// An all-zero middle tryte counts as non-negative and gets flagged.
		tval    = tryte_val(acc_q);
		flip    = n_zero ? (tval <= 5'sd0) : (tval >= 5'sd0);
		flipped = flip ? tryte_neg(acc_q) : acc_q;

		total_calc = zero_q ? POS_W'(ZERO_LEN) :
		             POS_W'({ntry_q, 1'b0}) + POS_W'(ntry_q) + POS_W'(flag_trits(ntry_q));
		cap_ok     = (cap_q >= total_calc);

		out_free = !m_valid_q || m_tready;
		out_load = out_free && ((state_q == ST_EMIT) || (state_q == ST_ERR));

		in_data  = (rd_try_q < ntry_q);
		rd_tryte = tbuf_q[rd_try_q];
		unique case (rd_sub_q)
			2'd0:    emit_trit = rd_tryte[1:0];
			2'd1:    emit_trit = rd_tryte[3:2];
			default: emit_trit = rd_tryte[5:4];
		endcase
		if (zero_q) begin
			emit_trit = zero_code(pos_q[1:0]);
		end else if (!in_data) begin
			emit_trit = fbuf_q[rd_flag_q];
		end
		emit_last = (POS_W'(pos_q + POS_W'(1)) == total_q);

		if (flag_mode_q) begin
			digit_next = (FLAG_IDX_W'(fcnt_q + FLAG_IDX_W'(1)) == clen_q) ? ST_EMIT : ST_INC;
		end else begin
			digit_next = (tsub_q == 2'd2) ? ST_TRYTE : ST_INC;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (value_in == '0) ? ST_LEN : ST_INC;
				end
			end
			ST_INC: begin
				state_d = n_zero ? digit_next : ST_DIV;
			end
			ST_DIV: begin
				if (chunk_q == '0) begin
					state_d = digit_next;
				end
			end
			ST_TRYTE: begin
				state_d = n_zero ? ST_LEN : ST_INC;
			end
			ST_LEN: begin
				if (!cap_ok) begin
					state_d = ST_ERR;
				end else begin
					state_d = zero_q ? ST_EMIT : ST_INC;
				end
			end
			ST_EMIT: begin
				if (out_free && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= '0;
			zero_q      <= 1'b0;
			flag_mode_q <= 1'b0;
			tsub_q      <= '0;
			ntry_q      <= '0;
			fcnt_q      <= '0;
			clen_q      <= '0;
			total_q     <= '0;
			pos_q       <= '0;
			rd_try_q    <= '0;
			rd_sub_q    <= '0;
			rd_flag_q   <= '0;
		end else begin
			state_q <= state_d;
			if (digit_done) begin
				if (flag_mode_q) begin
					fcnt_q <= FLAG_IDX_W'(fcnt_q + FLAG_IDX_W'(1));
				end else begin
					tsub_q <= (tsub_q == 2'd2) ? 2'd0 : 2'(tsub_q + 2'd1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						zero_q      <= (value_in == '0);
						flag_mode_q <= 1'b0;
						tsub_q      <= '0;
						ntry_q      <= '0;
						fcnt_q      <= '0;
					end
				end
				ST_INC: begin
					chunk_q <= CHUNK_IDX_W'(N_CHUNKS - 1);
				end
				ST_DIV: begin
					chunk_q <= CHUNK_IDX_W'(chunk_q - CHUNK_IDX_W'(1));
				end
				ST_TRYTE: begin
					ntry_q <= TRYTE_IDX_W'(ntry_q + TRYTE_IDX_W'(1));
				end
				ST_LEN: begin
					total_q     <= total_calc;
					clen_q      <= flag_trits(ntry_q);
					flag_mode_q <= 1'b1;
					fcnt_q      <= '0;
					pos_q       <= '0;
					rd_try_q    <= '0;
					rd_sub_q    <= '0;
					rd_flag_q   <= '0;
				end
				ST_EMIT: begin
					if (out_free) begin
						pos_q <= POS_W'(pos_q + POS_W'(1));
						if (in_data) begin
							if (rd_sub_q == 2'd2) begin
								rd_sub_q <= '0;
								rd_try_q <= TRYTE_IDX_W'(rd_try_q + TRYTE_IDX_W'(1));
							end else begin
								rd_sub_q <= 2'(rd_sub_q + 2'd1);
							end
						end else begin
							rd_flag_q <= FLAG_IDX_W'(rd_flag_q + FLAG_IDX_W'(1));
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working value, trit buffers and flag word.
	always_ff @(posedge clk) begin
		if (digit_done) begin
			if (flag_mode_q) begin
				fbuf_q[fcnt_q] <= raw_trit;
			end else begin
				acc_q[{tsub_q, 1'b0} +: TRIT_W] <= data_trit;
			end
		end
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					n_q     <= mag_in;
					neg_q   <= value_in[VALUE_W-1];
					cap_q   <= cap_in;
					flags_q <= '0;
				end
			end
			ST_INC: begin
				if (!n_zero) begin
					n_q <= n_q + VALUE_W'(1);
				end
				rem_q <= '0;
			end
			ST_DIV: begin
				n_q   <= {n_q[VALUE_W-CHUNK_W-1:0], div_res.quot};
				rem_q <= div_res.rem;
			end
			ST_TRYTE: begin
				tbuf_q[ntry_q]  <= flipped;
				flags_q[ntry_q] <= flip;
			end
			ST_LEN: begin
				n_q <= VALUE_W'(flags_q);
			end
			default: begin
			end
		endcase
	end

	// Output register: the sequencer refills it in the cycle the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_ERR) begin
				m_trit_q   <= TRIT_ZERO;
				m_pos_q    <= '0;
				m_last_q   <= 1'b1;
				m_status_q <= 1'b1;
			end else begin
				m_trit_q   <= emit_trit;
				m_pos_q    <= pos_q;
				m_last_q   <= emit_last;
				m_status_q <= 1'b0;
			end
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {m_pos_q, m_trit_q};
	assign m_tlast    = m_last_q;
	assign m_tuser[0] = m_status_q;

	// A capacity error is always the one and only result of its item.
	ast_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("capacity error result without last");

	// Once an item is taken the block stays busy for at least the next cycle.
	ast_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// The tryte count never runs past the buffer.
	ast_tryte_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ntry_q <= TRYTE_IDX_W'(MAX_TRYTES))
		else $error("tryte count overflow");

	// The chunk remainder of a division by three stays below three.
	ast_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q != 2'd3)
		else $error("divide remainder out of range");

endmodule

// ----- rtl/stle_div3.sv -----
`timescale 1ns / 1ps
// Divide-by-three step over one chunk with the remainder carried in from the chunk above.
module stle_div3 import stle_pkg::*; (
	input  logic [1:0]         rem_in,
	input  logic [CHUNK_W-1:0] chunk,
	output div_res_t           res
);

	logic [DIV_IN_W-1:0]            dividend;
	logic [DIV_IN_W+DIV_MULT_W-1:0] prod;
	logic [CHUNK_W-1:0]             quot;
	logic [DIV_IN_W-1:0]            back;
	logic [DIV_IN_W-1:0]            diff;

	assign dividend = {rem_in, chunk};
	// Reciprocal multiply; the dividend stays below 3 * 2^16, so the result is exact.
	assign prod = {{DIV_MULT_W{1'b0}}, dividend} * {{DIV_IN_W{1'b0}}, DIV_MULT};
	assign quot = prod[DIV_SHIFT +: CHUNK_W];
	assign back = {2'b00, quot} + {1'b0, quot, 1'b0};
	assign diff = dividend - back;

	assign res.quot = quot;
	assign res.rem  = diff[1:0];

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench: stream stimulus for the tryte length encoder, checked trit by trit.
module tb import stle_pkg::*; ();

	localparam int N_DIRECTED   = 23;
	localparam int RANDOM_ITEMS = 360;
	localparam int DRAIN_CYCLES = 400;
	localparam int unsigned LIMIT_CYCLES = 2_000_000;
	localparam int MAX_DATA_TRITS = 42;
	localparam int MAX_CODE_TRITS = 52;

	localparam logic CAP_OK    = 1'b0;
	localparam logic CAP_SHORT = 1'b1;

	// How a directed row is checked: by the local model, or against a result typed in here.
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_BAD_CAP,
		CHK_ZERO_CODE
	} check_t;

	typedef struct packed {
		logic [63:0] value;
		logic [5:0]  cap;
		check_t      how;
	} stim_row_t;

	typedef struct packed {
		trit_t      trit;
		logic [5:0] position;
		logic       is_last;
		logic       status;
	} trit_result_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic            m_tlast;
	logic [0:0]      m_tuser;

	logic            no_gaps = 1'b0;
	int              errors = 0;
	int unsigned     cycle_count = 0;
	trit_result_t    trit_q[$];
	check_t          check_q[$];

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{64'd0,                  6'd4,  CHK_ZERO_CODE},
		'{64'd0,                  6'd63, CHK_ZERO_CODE},
		'{64'd0,                  6'd3,  CHK_BAD_CAP},
		'{64'd0,                  6'd0,  CHK_BAD_CAP},
		'{64'd1,                  6'd4,  CHK_MODEL},
		'{64'd1,                  6'd3,  CHK_BAD_CAP},
		'{64'hFFFF_FFFF_FFFF_FFFF, 6'd4,  CHK_MODEL},
		'{64'hFFFF_FFFF_FFFF_FFFF, 6'd3,  CHK_BAD_CAP},
		'{64'd13,                 6'd4,  CHK_MODEL},
		'{64'hFFFF_FFFF_FFFF_FFF3, 6'd4,  CHK_MODEL},
		'{64'd14,                 6'd8,  CHK_MODEL},
		'{64'd14,                 6'd7,  CHK_BAD_CAP},
		// 27 leaves an all-zero first tryte that still gets its flag bit.
		'{64'd27,                 6'd63, CHK_MODEL},
		'{64'hFFFF_FFFF_FFFF_FFE5, 6'd63, CHK_MODEL},
		// The most negative value takes the full 52 trits.
		'{64'h8000_0000_0000_0000, 6'd52, CHK_MODEL},
		'{64'h8000_0000_0000_0000, 6'd51, CHK_BAD_CAP},
		'{64'h8000_0000_0000_0000, 6'd63, CHK_MODEL},
		'{64'h7FFF_FFFF_FFFF_FFFF, 6'd52, CHK_MODEL},
		'{64'h7FFF_FFFF_FFFF_FFFF, 6'd51, CHK_BAD_CAP},
		'{64'h8000_0000_0000_0001, 6'd63, CHK_MODEL},
		'{64'h5555_5555_5555_5555, 6'd63, CHK_MODEL},
		'{64'hAAAA_AAAA_AAAA_AAAA, 6'd63, CHK_MODEL},
		'{64'h0000_0001_0000_0000, 6'd63, CHK_MODEL}
	};

	signed_tryte_length_encoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Fewest balanced trits that reach a magnitude, at least one.
	function automatic int digit_count(input logic [63:0] mag);
		int          n;
		logic [63:0] reach;
		n = 1;
		reach = 64'd1;
		while (mag > reach) begin
			reach = reach * 64'd3 + 64'd1;
			n++;
		end
		return n;
	endfunction

	// Total trits of the encoding; data_len gets the padded data part.
	function automatic int code_length(input logic [63:0] value, output int data_len);
		logic [63:0] mag;
		int          total;
		if (value == 64'd0) begin
			data_len = 0;
			return 4;
		end
		mag = value[63] ? -value : value;
		data_len = digit_count(mag);
		if (data_len % 3 != 0)
			data_len += 3 - data_len % 3;
		if (data_len > MAX_DATA_TRITS)
			data_len = MAX_DATA_TRITS;
		total = data_len + digit_count((64'd1 << (data_len / 3)) - 64'd1);
		return (total > MAX_CODE_TRITS) ? MAX_CODE_TRITS : total;
	endfunction

	// Lowest balanced digit of n; n is left with the digits above it.
	function automatic int balanced_digit(inout logic [63:0] n);
		int d;
		d = int'((n + 64'd1) % 64'd3) - 1;
		n = (n + 64'd1) / 64'd3;
		return d;
	endfunction

	function automatic void push_result(input trit_t trit, input int position,
			input logic is_last, input logic status);
		trit_result_t r;
		r.trit = trit;
		r.position = 6'(position);
		r.is_last = is_last;
		r.status = status;
		trit_q.push_back(r);
	endfunction

	// Queues the trits that one value and capacity should produce.
	function automatic void predict_code(input logic [63:0] value, input logic [5:0] cap);
		int          code [MAX_CODE_TRITS];
		int          data_len;
		int          total;
		int          trytes;
		int          v;
		logic        neg;
		logic [63:0] mag;
		logic [63:0] flags;
		total = code_length(value, data_len);
		if (int'(cap) < total) begin
			push_result(TRIT_ZERO, 0, 1'b1, CAP_SHORT);
			return;
		end
		foreach (code[i])
			code[i] = 0;
		if (value == 64'd0) begin
			code[0] = 1;
			code[3] = -1;
		end else begin
			neg = value[63];
			mag = neg ? -value : value;
			flags = '0;
			trytes = data_len / 3;
			for (int i = 0; i < data_len; i++)
				code[i] = neg ? -balanced_digit(mag) : balanced_digit(mag);
			// Every tryte but the last must come out negative, the last positive.
			for (int t = 0; t < trytes; t++) begin
				v = code[3*t] + 3 * code[3*t+1] + 9 * code[3*t+2];
				if ((t + 1 < trytes) ? (v >= 0) : (v <= 0)) begin
					flags[t] = 1'b1;
					for (int j = 0; j < 3; j++)
						code[3*t+j] = -code[3*t+j];
				end
			end
			for (int i = data_len; i < total; i++)
				code[i] = balanced_digit(flags);
		end
		for (int i = 0; i < total; i++)
			push_result(trit_t'(code[i]), i, i == total - 1, CAP_OK);
	endfunction

	task automatic send_item(input logic [63:0] value, input logic [5:0] cap,
			input check_t how);
		while (!no_gaps && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		check_q.push_back(how);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, cap, value};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		int          pick;
		pick = $urandom_range(99);
		v = {$urandom, $urandom};
		if (pick < 8)
			v = 64'd0;
		else if (pick < 12)
			v = 64'h8000_0000_0000_0000;
		else if (pick < 60) begin
			v = v >> $urandom_range(63);
			if ($urandom_range(1) == 1)
				v = -v;
		end
		return v;
	endfunction

	always @(posedge clk) begin
		m_tready <= no_gaps || ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Accepted items feed the expectations; accepted trits are checked against the oldest one.
	always @(posedge clk) begin : monitor
		trit_result_t got;
		trit_result_t want;
		check_t       how;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				how = check_q.pop_front();
				unique case (how)
					CHK_BAD_CAP: begin
						push_result(TRIT_ZERO, 0, 1'b1, CAP_SHORT);
					end
					CHK_ZERO_CODE: begin
						push_result(TRIT_POS, 0, 1'b0, CAP_OK);
						push_result(TRIT_ZERO, 1, 1'b0, CAP_OK);
						push_result(TRIT_ZERO, 2, 1'b0, CAP_OK);
						push_result(TRIT_NEG, 3, 1'b1, CAP_OK);
					end
					default: begin
						predict_code(s_tdata[63:0], s_tdata[69:64]);
					end
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.trit = m_tdata[1:0];
				got.position = m_tdata[7:2];
				got.is_last = m_tlast;
				got.status = m_tuser[0];
				if (trit_q.size() == 0) begin
					$error("unexpected trit %0d at position %0d",
						$signed(got.trit), got.position);
					errors++;
				end else begin
					want = trit_q.pop_front();
					if (got.trit != want.trit) begin
						$error("trit: expected %0d, got %0d",
							$signed(want.trit), $signed(got.trit));
						errors++;
					end
					if (got.position != want.position) begin
						$error("position: expected %0d, got %0d", want.position, got.position);
						errors++;
					end
					if (got.is_last != want.is_last) begin
						$error("last: expected %0d, got %0d", want.is_last, got.is_last);
						errors++;
					end
					if (got.status != want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		logic [63:0] value;
		int          data_len;
		int          total;
		int          cap;
		int          pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].value, directed_rows[i].cap, directed_rows[i].how);

		// Mostly capacities that fit, some just short, some anything at all.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_gaps <= (n >= 120 && n < 200);
			value = pick_value();
			total = code_length(value, data_len);
			pick = $urandom_range(99);
			if (pick < 70)
				cap = total + int'($urandom_range(11));
			else if (pick < 85)
				cap = total - 1 - int'($urandom_range(3));
			else
				cap = $urandom_range(63);
			if (cap > 63)
				cap = 63;
			send_item(value, 6'(cap), CHK_MODEL);
		end
		s_tvalid <= 1'b0;
		no_gaps <= 1'b0;

		@(posedge clk);
		while (trit_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (trit_q.size() != 0) begin
			$error("%0d expected trits never arrived", trit_q.size());
			errors++;
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
